// ===== design/rbet_pkg.sv =====
// shared types and constants for the rds burst error trapping decoder
// no dependencies; imported by every module of the design
package rbet_pkg;

   localparam int WORD_W    = 26;
   localparam int CHECK_W   = 10;
   localparam int TRAP_W    = 5;
   localparam int TOP_SHIFT = 20;
   localparam int CNT_W     = $clog2(WORD_W);

   localparam logic [CHECK_W:0]   GEN_POLY = 11'h5B9;
   localparam logic [CHECK_W-1:0] PREMULT  = 10'h31B;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SYND,
      ST_TRAP,
      ST_DELIVER
   } rbet_state_type;

   typedef struct packed {
      logic clear;
      logic step;
      logic data_bit;
   } rbet_ctl_type;

endpackage

// ===== design/rds_burst_error_trap_decoder_core.sv =====
// rds (26,16) burst error trapping decoder, top level with sequencer and output beat register
// a beat runs syndrome shifts over all codeword bits, then trap shifts until the error is
//   trapped or every trap position is tried, then a correction step once the output
//   register is free; a result may wait there while the next beat runs
// reset: synchronous active high, returns to idle and drops rsp_valid
// depends on rbet_pkg, rbet_chain, rbet_cell
module rds_burst_error_trap_decoder_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rbet_pkg::WORD_W-1:0]   req_codeword,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rbet_pkg::WORD_W-1:0]   rsp_corrected_word,
   output logic                          rsp_error_fixed,
   output logic                          rsp_uncorrectable
);
   import rbet_pkg::*;

   rbet_state_type state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [TRAP_W-1:0] pat_ff, pat_in;
   logic              found_ff, found_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] corr_ff, corr_in;
   logic              fixed_ff, fixed_in;
   logic              unc_ff, unc_in;

   rbet_ctl_type      ctl;
   logic [TRAP_W-1:0] pattern;
   logic              trapped;
   logic              out_free;

   rbet_chain u_chain (
      .clock   (clock),
      .ctl     (ctl),
      .pattern (pattern),
      .trapped (trapped)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      word_in      = word_ff;
      pat_in       = pat_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      corr_in      = corr_ff;
      fixed_in     = fixed_ff;
      unc_in       = unc_ff;
      ctl          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.clear = 1'b1;
               word_in   = req_codeword;
               cnt_in    = CNT_W'(WORD_W - 1);
               state_in  = ST_SYND;
            end
         end
         ST_SYND: begin
            ctl.step     = 1'b1;
            ctl.data_bit = word_ff[cnt_ff];
            if (cnt_ff == '0) begin
               cnt_in   = CNT_W'(TOP_SHIFT);
               state_in = ST_TRAP;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_TRAP: begin
            ctl.step = 1'b1;
            if (trapped) begin
               found_in = 1'b1;
               pat_in   = pattern;
               state_in = ST_DELIVER;
            end else if (cnt_ff == '0) begin
               found_in = 1'b0;
               pat_in   = '0;
               state_in = ST_DELIVER;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DELIVER: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               corr_in      = word_ff ^ (WORD_W'(pat_ff) << cnt_ff);
               fixed_in     = found_ff && (pat_ff != '0);
               unc_in       = !found_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      word_ff  <= word_in;
      pat_ff   <= pat_in;
      found_ff <= found_in;
      corr_ff  <= corr_in;
      fixed_ff <= fixed_in;
      unc_ff   <= unc_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_corrected_word = corr_ff;
   assign rsp_error_fixed    = fixed_ff;
   assign rsp_uncorrectable  = unc_ff;

   a_rise_from_deliver: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DELIVER))
      else $error("result beat raised outside the delivery step");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(fixed_ff && unc_ff))
      else $error("result beat both fixed and uncorrectable");

   a_trap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRAP) |-> (cnt_ff <= CNT_W'(TOP_SHIFT)))
      else $error("trap position out of range");

   a_synd_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SYND) |-> (cnt_ff <= CNT_W'(WORD_W - 1)))
      else $error("syndrome bit index out of range");

   a_synd_to_trap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SYND && cnt_ff == '0) |=> (state_ff == ST_TRAP))
      else $error("syndrome phase did not hand over to trap search");

endmodule

// ===== design/rbet_cell.sv =====
// one bit of the syndrome shift register with generator and premultiplier taps
// depends on rbet_pkg
module rbet_cell (
   input  logic                 clock,
   input  rbet_pkg::rbet_ctl_type ctl,
   input  logic                 carry_in,
   input  logic                 feedback,
   input  logic                 gen_tap,
   input  logic                 pre_tap,
   output logic                 bit_out,
   output logic                 bit_step
);
   import rbet_pkg::*;

   logic bit_ff;
   logic bit_in;

   assign bit_step = carry_in ^ (ctl.data_bit & pre_tap) ^ (feedback & gen_tap);

   always_comb begin
      if (ctl.clear) begin
         bit_in = 1'b0;
      end else if (ctl.step) begin
         bit_in = bit_step;
      end else begin
         bit_in = bit_ff;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
   end

   assign bit_out = bit_ff;

endmodule

// ===== design/rbet_chain.sv =====
// row of syndrome cells, each passing its bit to the next one up
// depends on rbet_pkg and rbet_cell
module rbet_chain (
   input  logic                         clock,
   input  rbet_pkg::rbet_ctl_type       ctl,
   output logic [rbet_pkg::TRAP_W-1:0]  pattern,
   output logic                         trapped
);
   import rbet_pkg::*;

   logic [CHECK_W-1:0] syn;
   logic [CHECK_W-1:0] syn_step;

   for (genvar i = 0; i < CHECK_W; i++) begin : g_cell
      logic carry;
      if (i == 0) begin : g_first
         assign carry = 1'b0;
      end else begin : g_rest
         assign carry = syn[i-1];
      end
      rbet_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .carry_in (carry),
         .feedback (syn[CHECK_W-1]),
         .gen_tap  (GEN_POLY[i]),
         .pre_tap  (PREMULT[i]),
         .bit_out  (syn[i]),
         .bit_step (syn_step[i])
      );
   end

   // trap test on the value the next shift produces
   assign trapped = (syn_step[TRAP_W-1:0] == '0);
   assign pattern = syn_step[CHECK_W-1:CHECK_W-TRAP_W];

endmodule
